### rtl/lmsa_pkg.sv
// ============================================================================
// LED matrix scan animator package
// Shared types, codes, reset values and fixed field widths.
// ============================================================================
`default_nettype none

package lmsa_pkg;

  // Default geometry of the matrix and the frame store.
  localparam int NUM_FRAMES_DEF  = 8;
  localparam int NUM_ROWS_DEF    = 4;
  localparam int NUM_COLUMNS_DEF = 5;

  // Fixed widths of the request and result fields.
  localparam int OP_W       = 2;
  localparam int FRAME_W    = 3;
  localparam int WORD_W     = 5;
  localparam int ROW_OUT_W  = 4;
  localparam int PERIOD_W   = 16;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 4;

  // Number of row words carried by a write request.
  localparam int WORDS_PER_WRITE = 4;

  // Register reset values.
  localparam logic [FRAME_W-1:0]  LAST_FRAME_RST   = 3'd6;
  localparam logic [PERIOD_W-1:0] FRAME_PERIOD_RST = 16'd50;
  localparam logic                REPEAT_RST       = 1'b0;

  // Operation codes of a request.
  typedef enum logic [OP_W-1:0] {
    OP_TICK    = 2'd0,
    OP_WRITE   = 2'd1,
    OP_TRIGGER = 2'd2
  } op_t;

  // Register indexes on the configuration port.
  typedef enum logic [1:0] {
    REG_LAST_FRAME   = 2'd0,
    REG_FRAME_PERIOD = 2'd1,
    REG_REPEAT       = 2'd2
  } reg_idx_t;

  // Configuration register set.
  typedef struct packed {
    logic [FRAME_W-1:0]  last_frame;
    logic [PERIOD_W-1:0] frame_period;
    logic                repeat_enable;
  } cfg_t;

  // Control fields of a request on its way from the sequencer to the output stage.
  typedef struct packed {
    logic                 is_tick;
    logic                 word_valid;
    logic [ROW_OUT_W-1:0] row_drive;
    logic                 row_wrap;
    logic                 animating;
    logic [FRAME_W-1:0]   current_frame;
  } stage_t;

endpackage

`default_nettype wire

### rtl/lmsa_ram.sv
// ============================================================================
// Generic simple dual-port RAM
// One write port and one read port with a registered read and read enable.
// ============================================================================
`default_nettype none

module lmsa_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port; the data holds while no read is enabled.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

`default_nettype wire

### rtl/lmsa_cfg.sv
// ============================================================================
// LED matrix scan animator configuration registers
// APB-style register file holding the animation settings.
// ============================================================================
`default_nettype none

module lmsa_cfg
  import lmsa_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready,
  output cfg_t                       cfg
);

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_req;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr_req = psel && penable && pwrite;
  assign cfg    = cfg_r;

  // Register write decode; an address beyond the list is ignored.
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_req) begin
      unique case (idx)
        REG_LAST_FRAME:   cfg_nxt.last_frame    = pwdata[FRAME_W-1:0];
        REG_FRAME_PERIOD: cfg_nxt.frame_period  = pwdata[PERIOD_W-1:0];
        REG_REPEAT:       cfg_nxt.repeat_enable = pwdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.last_frame    <= LAST_FRAME_RST;
      cfg_r.frame_period  <= FRAME_PERIOD_RST;
      cfg_r.repeat_enable <= REPEAT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Read-back multiplexer.
  always_comb begin
    unique case (idx)
      REG_LAST_FRAME:   prdata = APB_DATA_W'(cfg_r.last_frame);
      REG_FRAME_PERIOD: prdata = APB_DATA_W'(cfg_r.frame_period);
      REG_REPEAT:       prdata = APB_DATA_W'(cfg_r.repeat_enable);
      default:          prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

### rtl/lmsa_seq.sv
// ============================================================================
// LED matrix scan animator sequencer
// Scan ring, tick counter and frame index update, frame store access.
// ============================================================================
`default_nettype none

module lmsa_seq
  import lmsa_pkg::*;
#(
  parameter int NUM_FRAMES  = NUM_FRAMES_DEF,
  parameter int NUM_ROWS    = NUM_ROWS_DEF,
  parameter int NUM_COLUMNS = NUM_COLUMNS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  cfg_t                                 cfg,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [OP_W-1:0]                 in_operation,
  input  wire logic [FRAME_W-1:0]              in_frame_number,
  input  wire logic [WORD_W-1:0]               in_row_word_0,
  input  wire logic [WORD_W-1:0]               in_row_word_1,
  input  wire logic [WORD_W-1:0]               in_row_word_2,
  input  wire logic [WORD_W-1:0]               in_row_word_3,
  input  wire logic                            b_ready,
  output logic                                 b_valid,
  output stage_t                               b_stage,
  output logic [$clog2(NUM_ROWS)-1:0]          b_row_sel,
  output logic                                 ram_wr_en,
  output logic [$clog2(NUM_FRAMES)-1:0]        ram_wr_addr,
  output logic [NUM_ROWS*NUM_COLUMNS-1:0]      ram_wr_data,
  output logic                                 ram_rd_en,
  output logic [$clog2(NUM_FRAMES)-1:0]        ram_rd_addr
);

  localparam int FI_W  = $clog2(NUM_FRAMES);
  localparam int RI_W  = $clog2(NUM_ROWS);
  localparam int CMP_W = (FI_W > FRAME_W) ? FI_W : FRAME_W;

  logic [NUM_ROWS-1:0]   ring_r,  ring_nxt;
  logic [RI_W-1:0]       ci_r,    ci_nxt;
  logic [RI_W-1:0]       ci_use;
  logic [PERIOD_W-1:0]   cnt_r,   cnt_nxt;
  logic [FI_W-1:0]       fi_r,    fi_nxt;
  logic                  anim_r,  anim_nxt;
  logic [NUM_FRAMES-1:0] fvalid_r, fvalid_nxt;
  logic                  sync_now;
  logic                  passed;
  logic                  accept;
  logic                  is_tick;
  logic                  b_en;
  logic                  b_valid_r;
  stage_t                b_stage_r;
  logic [RI_W-1:0]       b_row_sel_r;
  logic [WORD_W-1:0]     words [WORDS_PER_WRITE];
  op_t                   op;

  // The stage ahead of the output takes a request when it is empty or drains.
  assign b_en     = !b_valid_r || b_ready;
  assign in_stall = !b_en;
  assign accept   = in_valid && b_en;
  assign op       = op_t'(in_operation);
  assign is_tick  = (op == OP_TICK);

  assign words[0] = in_row_word_0;
  assign words[1] = in_row_word_1;
  assign words[2] = in_row_word_2;
  assign words[3] = in_row_word_3;

  // Next scan and animation state for the accepted request.
  always_comb begin
    ring_nxt   = ring_r;
    ci_nxt     = ci_r;
    ci_use     = ci_r;
    cnt_nxt    = cnt_r;
    fi_nxt     = fi_r;
    anim_nxt   = anim_r;
    fvalid_nxt = fvalid_r;
    sync_now   = 1'b0;
    passed     = 1'b0;
    ram_wr_en  = 1'b0;
    if (accept) begin
      unique case (op)
        OP_TICK: begin
          // The ring wraps to the first row and restarts the row word index.
          if (ring_r[NUM_ROWS-1]) begin
            ring_nxt = NUM_ROWS'(1);
            ci_use   = '0;
            sync_now = 1'b1;
          end else begin
            ring_nxt = ring_r << 1;
          end
          passed = (cnt_r > cfg.frame_period);
          if (cnt_r != '1) begin
            cnt_nxt = cnt_r + 1'b1;
          end
          if (passed && sync_now) begin
            cnt_nxt = '0;
            if (anim_r) begin
              if ((CMP_W'(fi_r) >= CMP_W'(cfg.last_frame)) ||
                  (fi_r == FI_W'(NUM_FRAMES - 1))) begin
                fi_nxt   = '0;
                anim_nxt = cfg.repeat_enable;
              end else begin
                fi_nxt = fi_r + 1'b1;
              end
            end
          end
          ci_nxt = (ci_use == RI_W'(NUM_ROWS - 1)) ? '0 : ci_use + 1'b1;
        end
        OP_WRITE: begin
          if (in_frame_number < NUM_FRAMES) begin
            ram_wr_en = 1'b1;
            fvalid_nxt[FI_W'(in_frame_number)] = 1'b1;
          end
        end
        OP_TRIGGER: begin
          anim_nxt = 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Frame write data: rows past the carried words stay dark.
  always_comb begin
    ram_wr_data = '0;
    for (int r = 0; r < NUM_ROWS; r++) begin
      if (r < WORDS_PER_WRITE) begin
        ram_wr_data[r*NUM_COLUMNS +: NUM_COLUMNS] = NUM_COLUMNS'(words[2'(r)]);
      end
    end
  end

  assign ram_wr_addr = FI_W'(in_frame_number);
  assign ram_rd_en   = accept;
  assign ram_rd_addr = fi_nxt;

  // Scan and animation state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_r   <= NUM_ROWS'(1);
      ci_r     <= '0;
      cnt_r    <= '0;
      fi_r     <= '0;
      anim_r   <= 1'b0;
      fvalid_r <= '0;
    end else begin
      ring_r   <= ring_nxt;
      ci_r     <= ci_nxt;
      cnt_r    <= cnt_nxt;
      fi_r     <= fi_nxt;
      anim_r   <= anim_nxt;
      fvalid_r <= fvalid_nxt;
    end
  end

  // Stage register alongside the frame store read.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (b_en) begin
      b_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_stage_r.is_tick       <= is_tick;
      b_stage_r.word_valid    <= fvalid_r[fi_nxt];
      b_stage_r.row_drive     <= ROW_OUT_W'(ring_nxt);
      b_stage_r.row_wrap      <= sync_now;
      b_stage_r.animating     <= anim_nxt;
      b_stage_r.current_frame <= FRAME_W'(fi_nxt);
      b_row_sel_r             <= ci_use;
    end
  end

  assign b_valid   = b_valid_r;
  assign b_stage   = b_stage_r;
  assign b_row_sel = b_row_sel_r;

endmodule

`default_nettype wire

### rtl/lmsa_out.sv
// ============================================================================
// LED matrix scan animator output stage
// Row word selection, column latch and the result register.
// ============================================================================
`default_nettype none

module lmsa_out
  import lmsa_pkg::*;
#(
  parameter int NUM_ROWS    = NUM_ROWS_DEF,
  parameter int NUM_COLUMNS = NUM_COLUMNS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            b_valid,
  input  stage_t                               b_stage,
  input  wire logic [$clog2(NUM_ROWS)-1:0]     b_row_sel,
  input  wire logic [NUM_ROWS*NUM_COLUMNS-1:0] rd_data,
  output logic                                 b_ready,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [ROW_OUT_W-1:0]                 out_row_drive,
  output logic [WORD_W-1:0]                    out_column_drive,
  output logic                                 out_row_wrap,
  output logic                                 out_animating,
  output logic [FRAME_W-1:0]                   out_current_frame
);

  logic                   out_valid_r;
  logic [NUM_COLUMNS-1:0] col_r;
  logic [NUM_COLUMNS-1:0] word;
  logic [ROW_OUT_W-1:0]   row_r;
  logic                   sync_r;
  logic                   anim_r;
  logic [FRAME_W-1:0]     frame_r;
  logic                   load;

  assign b_ready = !out_valid_r || !out_stall;
  assign load    = b_valid && b_ready;

  // A frame never written reads as dark.
  assign word = b_stage.word_valid ? rd_data[b_row_sel*NUM_COLUMNS +: NUM_COLUMNS] : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (b_ready) begin
      out_valid_r <= b_valid;
    end
  end

  // The column latch changes only on a tick and is shown for every result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '1;
    end else if (load && b_stage.is_tick) begin
      col_r <= ~word;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      row_r   <= b_stage.row_drive;
      sync_r  <= b_stage.row_wrap;
      anim_r  <= b_stage.animating;
      frame_r <= b_stage.current_frame;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_row_drive     = row_r;
  assign out_column_drive  = WORD_W'(col_r);
  assign out_row_wrap      = sync_r;
  assign out_animating     = anim_r;
  assign out_current_frame = frame_r;

endmodule

`default_nettype wire

### rtl/led_matrix_scan_animator_unit.sv
// ============================================================================
// LED matrix scan animator
// Multiplexed row-scan driver for an LED matrix with frame animation.
// ============================================================================
// Each request on the in_ channel gives exactly one result on the out_
// channel, in order. A refresh tick steps the one-hot row, paces the
// animation and drives the inverted column word of the current frame; a write
// loads the four row words of one frame; a trigger starts the animation.
// Settings (last frame, frame period, repeat) sit on an APB-style port. The
// user must write them only while no request is in flight; the block itself
// does not enforce this. A request passes the frame store read, registered
// with the stage register, and then the result register. One request is taken
// every cycle while in_stall is low; the rate is set by the read-modify-write
// of the scan state next to the registered read of the frame store.
// When the receiver stalls, the result register holds and the stage behind
// it still fills, so in_stall rises only once both are full.
// Reset is synchronous: row 0 active, counter, frame index and animation
// cleared, every column dark, and the whole frame store reads as dark until
// each frame is written. No clearing pass is needed.
// ============================================================================
`default_nettype none

module led_matrix_scan_animator_unit
  import lmsa_pkg::*;
#(
  parameter int NUM_FRAMES  = NUM_FRAMES_DEF,
  parameter int NUM_ROWS    = NUM_ROWS_DEF,
  parameter int NUM_COLUMNS = NUM_COLUMNS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [OP_W-1:0]       in_operation,
  input  wire logic [FRAME_W-1:0]    in_frame_number,
  input  wire logic [WORD_W-1:0]     in_row_word_0,
  input  wire logic [WORD_W-1:0]     in_row_word_1,
  input  wire logic [WORD_W-1:0]     in_row_word_2,
  input  wire logic [WORD_W-1:0]     in_row_word_3,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [ROW_OUT_W-1:0]       out_row_drive,
  output logic [WORD_W-1:0]          out_column_drive,
  output logic                       out_row_wrap,
  output logic                       out_animating,
  output logic [FRAME_W-1:0]         out_current_frame
);

  localparam int FI_W    = $clog2(NUM_FRAMES);
  localparam int RI_W    = $clog2(NUM_ROWS);
  localparam int FRAME_B = NUM_ROWS * NUM_COLUMNS;

  cfg_t               cfg;
  logic               b_ready;
  logic               b_valid;
  stage_t             b_stage;
  logic [RI_W-1:0]    b_row_sel;
  logic               ram_wr_en;
  logic [FI_W-1:0]    ram_wr_addr;
  logic [FRAME_B-1:0] ram_wr_data;
  logic               ram_rd_en;
  logic [FI_W-1:0]    ram_rd_addr;
  logic [FRAME_B-1:0] ram_rd_data;

  // Configuration registers.
  lmsa_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Scan sequencer and frame store access.
  lmsa_seq #(
    .NUM_FRAMES  (NUM_FRAMES),
    .NUM_ROWS    (NUM_ROWS),
    .NUM_COLUMNS (NUM_COLUMNS)
  ) u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_frame_number (in_frame_number),
    .in_row_word_0   (in_row_word_0),
    .in_row_word_1   (in_row_word_1),
    .in_row_word_2   (in_row_word_2),
    .in_row_word_3   (in_row_word_3),
    .b_ready         (b_ready),
    .b_valid         (b_valid),
    .b_stage         (b_stage),
    .b_row_sel       (b_row_sel),
    .ram_wr_en       (ram_wr_en),
    .ram_wr_addr     (ram_wr_addr),
    .ram_wr_data     (ram_wr_data),
    .ram_rd_en       (ram_rd_en),
    .ram_rd_addr     (ram_rd_addr)
  );

  // Frame store: one entry holds all row words of a frame.
  lmsa_ram #(
    .WIDTH (FRAME_B),
    .DEPTH (NUM_FRAMES)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // Column latch and result register.
  lmsa_out #(
    .NUM_ROWS    (NUM_ROWS),
    .NUM_COLUMNS (NUM_COLUMNS)
  ) u_out (
    .clk               (clk),
    .rst_n             (rst_n),
    .b_valid           (b_valid),
    .b_stage           (b_stage),
    .b_row_sel         (b_row_sel),
    .rd_data           (ram_rd_data),
    .b_ready           (b_ready),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_row_drive     (out_row_drive),
    .out_column_drive  (out_column_drive),
    .out_row_wrap      (out_row_wrap),
    .out_animating     (out_animating),
    .out_current_frame (out_current_frame)
  );

endmodule

`default_nettype wire

### rtl/lmsa_chk.sv
// ============================================================================
// LED matrix scan animator port checker
// Concurrent checks on the top-level ports, bound to the top level.
// ============================================================================
`default_nettype none

module lmsa_chk
  import lmsa_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 out_valid,
  input wire logic                 out_stall,
  input wire logic [ROW_OUT_W-1:0] out_row_drive,
  input wire logic [WORD_W-1:0]    out_column_drive,
  input wire logic                 out_row_wrap
);

  // No result is offered straight out of reset.
  a_reset_empty: assert property (@(posedge clk) $rose(rst_n) |-> !out_valid)
    else $error("result offered straight after reset");

  // At most one row is driven in an offered result.
  a_row_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot0(out_row_drive))
    else $error("more than one row driven");

  // A scan wrap always comes with the first row.
  a_sync_row0: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_row_wrap) |-> (out_row_drive == ROW_OUT_W'(1)))
    else $error("scan wrap without the first row");

  // A stalled result stays offered and unchanged.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_row_drive) && $stable(out_column_drive)))
    else $error("stalled result dropped or changed");

endmodule

bind led_matrix_scan_animator_unit lmsa_chk u_lmsa_chk (.*);

`default_nettype wire
